### rtl/mdm_pkg.sv
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared types, constants and the quarter-wave sine table of the mecanum
// drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdm_pkg;

   // Depth of the queue between the pattern front end and the mixing back end.
   localparam int QUEUE_DEPTH = 4;

   // Highest table index of the quarter-wave sine table (90 degrees).
   localparam int SINE_LAST = 90;

   // One drive command.
   typedef struct packed {
      logic        [8:0]  heading_deg;
      logic signed [15:0] power_level;
      logic signed [15:0] turn_level;
   } req_type;

   // Four wheel drives.
   typedef struct packed {
      logic signed [15:0] wheel0_drive;
      logic signed [15:0] wheel1_drive;
      logic signed [15:0] wheel2_drive;
      logic signed [15:0] wheel3_drive;
   } rsp_type;

   // sin(k degrees) scaled by 32768 and rounded, k = 0 to 90.
   localparam logic [15:0] QUARTER_SINE [SINE_LAST+1] = '{
          16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
       16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
       16'd7927,  16'd8481,  16'd9032,  16'd9581, 16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   // Table lookup; indexes past 90 degrees never occur and read as zero.
   function automatic logic [15:0] quarter_sine(input logic [6:0] k);
      logic [15:0] val;
      val = 16'd0;
      if (int'(k) <= SINE_LAST) begin
         val = QUARTER_SINE[k];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

### rtl/mdm_divider.sv
// ----------------------------------------------------------------------------
// mdm_divider
// Pipelined restoring divider: one quotient bit per stage, with a tag that
// travels alongside. The dividend must be below divisor * 2^QW.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_divider #(
   parameter int NW,
   parameter int DW,
   parameter int QW,
   parameter int TW
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   input  wire logic [TW-1:0] tag_in,
   output logic               out_valid,
   output logic [QW-1:0]      quot,
   output logic [TW-1:0]      tag_out
);

   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] numb_ff [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [TW-1:0] tag_ff  [QW];
   logic [QW-1:0] valid_ff;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_p;
      logic [QW-1:0] numb_p;
      logic [DW-1:0] den_p;
      logic [TW-1:0] tag_p;
      logic          valid_p;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] numb_in;

      // The first stage takes the upper dividend bits as its partial remainder.
      if (k == 0) begin : g_first
         assign rem_p   = DW'(numer >> QW);
         assign numb_p  = numer[QW-1:0];
         assign den_p   = denom;
         assign tag_p   = tag_in;
         assign valid_p = in_valid;
      end else begin : g_next
         assign rem_p   = rem_ff[k-1];
         assign numb_p  = numb_ff[k-1];
         assign den_p   = den_ff[k-1];
         assign tag_p   = tag_ff[k-1];
         assign valid_p = valid_ff[k-1];
      end

      // Shift in the next dividend bit and subtract when the divisor fits.
      always_comb begin
         trial   = {rem_p, numb_p[QW-1]};
         diff    = trial - {1'b0, den_p};
         ge      = (trial >= {1'b0, den_p});
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         numb_in = {numb_p[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            numb_ff[k] <= numb_in;
            den_ff[k]  <= den_p;
            tag_ff[k]  <= tag_p;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quot      = numb_ff[QW-1];
   assign tag_out   = tag_ff[QW-1];

endmodule

`default_nettype wire

### rtl/mdm_queue.sv
// ----------------------------------------------------------------------------
// mdm_queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_queue
   import mdm_pkg::*;
#(
   parameter int W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ok,
   input  wire logic [W-1:0] push_data,
   output logic              pop_valid,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [W-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   // A full queue still takes a request in the cycle that it gives one away.
   assign pop_valid = (count_ff != CW'(0));
   assign push_ok   = (count_ff != CW'(QUEUE_DEPTH)) || pop;
   assign do_push   = push_valid && push_ok;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop  ? PW'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/mdm_front.sv
// ----------------------------------------------------------------------------
// mdm_front
// Front end: takes drive requests, looks up sine and cosine of the heading
// and divides out the normalized translation pattern A', B'.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_front
   import mdm_pkg::*;
#(
   parameter int FRAC_BITS,
   parameter int QW_PAT = FRAC_BITS + 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         push_valid,
   input  wire logic    push_ok,
   output logic [2*QW_PAT+31:0] push_data
);

   localparam int NW = FRAC_BITS + 18;
   localparam int QW = FRAC_BITS + 1;

   logic               en;
   logic [8:0]         h_red;
   logic [8:0]         h_cos;
   logic signed [16:0] s_val;
   logic signed [16:0] c_val;

   logic               valid_ff;
   logic signed [17:0] sum_ff, sum_in;
   logic signed [17:0] dif_ff, dif_in;
   logic [16:0]        den_ff, den_in;
   logic signed [15:0] pw_ff;
   logic signed [15:0] tn_ff;

   logic [16:0]        mag_a, mag_b;
   logic [NW-1:0]      num_a, num_b;
   logic               a_valid;
   logic [QW-1:0]      q_a, q_b;
   logic [32:0]        tag_a;
   logic [0:0]         tag_b;
   logic signed [QW_PAT-1:0] pat_a, pat_b;

   // Sine of a heading in 0 to 359 degrees, scaled by 32768.
   function automatic logic signed [16:0] sine_of(input logic [8:0] h);
      logic [1:0]  quad;
      logic [8:0]  rem;
      logic [6:0]  idx;
      logic [16:0] mag;
      if (h >= 9'd270) begin
         quad = 2'd3;
         rem  = h - 9'd270;
      end else if (h >= 9'd180) begin
         quad = 2'd2;
         rem  = h - 9'd180;
      end else if (h >= 9'd90) begin
         quad = 2'd1;
         rem  = h - 9'd90;
      end else begin
         quad = 2'd0;
         rem  = h;
      end
      idx = quad[0] ? 7'(9'd90 - rem) : rem[6:0];
      mag = {1'b0, quarter_sine(idx)};
      return quad[1] ? -signed'(mag) : signed'(mag);
   endfunction

   // The front end holds while its last stage waits on a full queue.
   assign en        = !(a_valid && !push_ok);
   assign req_ready = en;

   // Headings past 359 wrap once; cosine is the sine 90 degrees ahead.
   always_comb begin
      h_red  = (req_payload.heading_deg >= 9'd360) ?
               9'(req_payload.heading_deg - 9'd360) : req_payload.heading_deg;
      h_cos  = (h_red >= 9'd270) ? 9'(h_red - 9'd270) : 9'(h_red + 9'd90);
      s_val  = sine_of(h_red);
      c_val  = sine_of(h_cos);
      sum_in = 18'(s_val) + 18'(c_val);
      dif_in = 18'(s_val) - 18'(c_val);
      den_in = 17'((s_val < 0) ? -s_val : s_val) + 17'((c_val < 0) ? -c_val : c_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         dif_ff <= dif_in;
         den_ff <= den_in;
         pw_ff  <= req_payload.power_level;
         tn_ff  <= req_payload.turn_level;
      end
   end

   // Rounded dividends: |s +- c| * 2^FRAC_BITS + den / 2.
   always_comb begin
      mag_a = 17'((sum_ff < 0) ? -sum_ff : sum_ff);
      mag_b = 17'((dif_ff < 0) ? -dif_ff : dif_ff);
      num_a = (NW'(mag_a) << FRAC_BITS) + NW'(den_ff >> 1);
      num_b = (NW'(mag_b) << FRAC_BITS) + NW'(den_ff >> 1);
   end

   mdm_divider #(.NW(NW), .DW(17), .QW(QW), .TW(33)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (valid_ff),
      .numer    (num_a),
      .denom    (den_ff),
      .tag_in   ({sum_ff[17], pw_ff, tn_ff}),
      .out_valid(a_valid),
      .quot     (q_a),
      .tag_out  (tag_a)
   );

   mdm_divider #(.NW(NW), .DW(17), .QW(QW), .TW(1)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (valid_ff),
      .numer    (num_b),
      .denom    (den_ff),
      .tag_in   (dif_ff[17]),
      .out_valid(),
      .quot     (q_b),
      .tag_out  (tag_b)
   );

   // Restore the signs of the pattern values.
   always_comb begin
      pat_a = tag_a[32] ? -signed'(QW_PAT'(q_a)) : signed'(QW_PAT'(q_a));
      pat_b = tag_b[0]  ? -signed'(QW_PAT'(q_b)) : signed'(QW_PAT'(q_b));
   end

   assign push_valid = a_valid;
   assign push_data  = {pat_a, pat_b, tag_a[31:0]};

endmodule

`default_nettype wire

### rtl/mdm_back.sv
// ----------------------------------------------------------------------------
// mdm_back
// Back end: mixes pattern, power and turn into four wheel values, finds the
// peak magnitude, rescales when it exceeds one and saturates to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_back
   import mdm_pkg::*;
#(
   parameter int FRAC_BITS,
   parameter int QW_PAT = FRAC_BITS + 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   output logic         pop,
   input  wire logic [2*QW_PAT+31:0] pop_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int VW = FRAC_BITS + 18;
   localparam int AW = FRAC_BITS + 17;
   localparam int NW = FRAC_BITS + 33;
   localparam int QW = 17;
   localparam int TW = 19;
   localparam logic [AW-1:0] ONE = AW'(1) << (FRAC_BITS + 15);

   logic en;
   logic free;
   logic last_valid;

   logic signed [QW_PAT-1:0] pat_a, pat_b;
   logic signed [15:0]       pw, tn;
   logic signed [VW-1:0]     prod_a, prod_b, turn_term;
   logic signed [VW-1:0]     v_in [4];

   logic                 v_valid_ff;
   logic signed [VW-1:0] v_ff [4];

   logic [AW-1:0]  abs_in [4];
   logic [AW-1:0]  peak_lo, peak_hi, peak_in;
   logic [16:0]    small_in [4];

   logic           m_valid_ff;
   logic [AW-1:0]  abs_ff [4];
   logic [3:0]     neg_ff;
   logic [16:0]    small_ff [4];
   logic [AW-1:0]  peak_ff;
   logic           over_ff;

   logic [3:0]     d_valid;
   logic [QW-1:0]  d_quot [4];
   logic [TW-1:0]  d_tag [4];
   logic [15:0]    drive_in [4];

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff;

   // The whole back end advances whenever the output register can take a result or its last stage is empty.
   assign free = !rsp_valid_ff || rsp_ready;
   assign en   = free || !last_valid;
   assign pop  = en && pop_valid;

   // Mix: pattern times power plus turn with the rotation signs -, +, +, -.
   always_comb begin
      {pat_a, pat_b, pw, tn} = pop_data;
      prod_a    = pat_a * pw;
      prod_b    = pat_b * pw;
      turn_term = VW'(tn) <<< FRAC_BITS;
      v_in[0]   = prod_a - turn_term;
      v_in[1]   = prod_b + turn_term;
      v_in[2]   = prod_a + turn_term;
      v_in[3]   = prod_b - turn_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (en) begin
         v_valid_ff <= pop_valid;
         m_valid_ff <= v_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   // Magnitudes, their peak and the plain rounded scale-down.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         abs_in[i]   = AW'((v_ff[i] < 0) ? -v_ff[i] : v_ff[i]);
         small_in[i] = 17'((abs_in[i] + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      end
      peak_lo = (abs_in[0] > abs_in[1]) ? abs_in[0] : abs_in[1];
      peak_hi = (abs_in[2] > abs_in[3]) ? abs_in[2] : abs_in[3];
      peak_in = (peak_lo > peak_hi) ? peak_lo : peak_hi;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            abs_ff[i]   <= abs_in[i];
            neg_ff[i]   <= v_ff[i][VW-1];
            small_ff[i] <= small_in[i];
         end
         peak_ff <= peak_in;
         over_ff <= (peak_in > ONE);
      end
   end

   // Rescale by the peak: round(|v| * 32768 / peak), one divider per wheel.
   for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [NW-1:0] num;
      assign num = (NW'(abs_ff[i]) << 15) + NW'(peak_ff >> 1);

      mdm_divider #(.NW(NW), .DW(AW), .QW(QW), .TW(TW)) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (m_valid_ff),
         .numer    (num),
         .denom    (peak_ff),
         .tag_in   ({neg_ff[i], over_ff, small_ff[i]}),
         .out_valid(d_valid[i]),
         .quot     (d_quot[i]),
         .tag_out  (d_tag[i])
      );
   end

   assign last_valid = d_valid[0];

   // Pick the rescaled or plain magnitude, restore the sign and saturate.
   always_comb begin
      logic [16:0] mag;
      for (int i = 0; i < 4; i++) begin
         mag = d_tag[i][17] ? d_quot[i] : d_tag[i][16:0];
         if (d_tag[i][18]) begin
            drive_in[i] = 16'(-mag);
         end else if (mag > 17'd32767) begin
            drive_in[i] = 16'd32767;
         end else begin
            drive_in[i] = mag[15:0];
         end
      end
   end

   assign rsp_valid_in = free ? last_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && last_valid) begin
         rsp_ff.wheel0_drive <= drive_in[0];
         rsp_ff.wheel1_drive <= drive_in[1];
         rsp_ff.wheel2_drive <= drive_in[2];
         rsp_ff.wheel3_drive <= drive_in[3];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### rtl/mecanum_drive_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_drive_mixer
// Turns a drive request (heading, power, turn) into four mecanum wheel drives.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req_payload) takes a heading in
// degrees and signed Q1.15 power and turn levels. The response channel
// (rsp_valid, rsp_ready, rsp_payload) returns four signed Q1.15 wheel drives,
// one response per request, in order.
// A new request is taken in every cycle unless the front end holds on a
// full queue. The front end (sine lookup and a FRAC_BITS + 1 stage pattern
// divider) feeds a four-entry queue; the back end (mix, peak search, 17 stage
// rescale divider, output register) drains it.
// When the receiver stalls, the back end holds, the queue absorbs up to four
// requests and the front end pipeline fills before req_ready drops. Reset
// empties the pipeline and the queue; there is no configuration and no stored
// state.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_drive_mixer
   import mdm_pkg::*;
#(
   parameter int FRAC_BITS = 15
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int QW_PAT = FRAC_BITS + 2;
   localparam int QDW    = 2 * QW_PAT + 32;

   logic           push_valid;
   logic           push_ok;
   logic [QDW-1:0] push_data;
   logic           pop_valid;
   logic           pop;
   logic [QDW-1:0] pop_data;

   mdm_front #(.FRAC_BITS(FRAC_BITS), .QW_PAT(QW_PAT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_ok    (push_ok),
      .push_data  (push_data)
   );

   mdm_queue #(.W(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ok   (push_ok),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   mdm_back #(.FRAC_BITS(FRAC_BITS), .QW_PAT(QW_PAT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

### sim/tb_mecanum_drive_mixer.sv
// ----------------------------------------------------------------------------
// tb_mecanum_drive_mixer
// Self-checking testbench of the mecanum drive mixer: directed and random
// drive requests, with random stalls on both channels, checked against an
// in-bench computation of the four wheel drives.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mecanum_drive_mixer;
   import mdm_pkg::*;

   localparam int FRAC = 15;
   localparam int LATENCY = FRAC + 22;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   rsp_type wheel_queue[$];
   int      mismatch_count;
   int      sent_count;
   int      checked_count;
   int      hold_cycles;
   bit      send_gaps;

   mecanum_drive_mixer #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Signed division rounded to nearest, ties away from zero.
   function automatic longint round_div(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // Sine of a heading in 0..359, scaled by 32768.
   function automatic longint heading_sine(input int h);
      int quad;
      int rem;
      longint mag;
      quad = (h / 90) % 4;
      rem = h % 90;
      mag = (quad % 2 == 1) ? longint'(QUARTER_SINE[90 - rem]) : longint'(QUARTER_SINE[rem]);
      return (quad >= 2) ? -mag : mag;
   endfunction

   // Wheel drives for one drive request.
   function automatic rsp_type mix_wheels(input req_type cmd);
      int      h;
      longint  s, c, den, pw, tn, peak, r;
      longint  pat[2];
      longint  v[4];
      longint  rot[4];
      rsp_type res;
      rot = '{-1, 1, 1, -1};
      h = int'(cmd.heading_deg);
      if (h >= 360) begin
         h = h - 360;
      end
      s = heading_sine(h);
      c = heading_sine((h + 90) % 360);
      den = ((s < 0) ? -s : s) + ((c < 0) ? -c : c);
      pat[0] = round_div((s + c) <<< FRAC, den);
      pat[1] = round_div((s - c) <<< FRAC, den);
      pw = longint'(cmd.power_level);
      tn = longint'(cmd.turn_level);
      peak = 0;
      for (int i = 0; i < 4; i++) begin
         v[i] = pat[i % 2] * pw + rot[i] * (tn <<< FRAC);
         if (((v[i] < 0) ? -v[i] : v[i]) > peak) begin
            peak = (v[i] < 0) ? -v[i] : v[i];
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (peak > (longint'(1) <<< (FRAC + 15))) begin
            r = round_div(v[i] * 32768, peak);
         end else begin
            r = round_div(v[i], longint'(1) <<< FRAC);
         end
         if (r > 32767) begin
            r = 32767;
         end
         if (r < -32768) begin
            r = -32768;
         end
         case (i)
            0: res.wheel0_drive = 16'(r);
            1: res.wheel1_drive = 16'(r);
            2: res.wheel2_drive = 16'(r);
            default: res.wheel3_drive = 16'(r);
         endcase
      end
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int random_gap();
      if ($urandom_range(99) < 5) begin
         return $urandom_range(40, 8);
      end
      return ($urandom_range(99) < 60) ? 0 : $urandom_range(3, 1);
   endfunction

   // Send one request, holding valid until it is accepted.
   task automatic send_request(input logic [8:0] hd, input logic [15:0] pw,
                               input logic [15:0] tn);
      req_type cmd;
      int      gap;
      bit      accepted;
      cmd.heading_deg = hd;
      cmd.power_level = pw;
      cmd.turn_level = tn;
      gap = send_gaps ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= cmd;
      wheel_queue.push_back(mix_wheels(cmd));
      // Ready is stable between edges, so sample it mid-cycle.
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (wheel_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Receiver: random stalls, plus an explicit hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (send_gaps) begin
         rsp_ready <= ($urandom_range(99) < 70);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response with the oldest expected one.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wheel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("ERROR: unexpected response %h", rsp_payload);
            end
         end else begin
            exp_rsp = wheel_queue.pop_front();
            checked_count++;
            if (rsp_payload !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: wheels expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     exp_rsp.wheel0_drive, exp_rsp.wheel1_drive, exp_rsp.wheel2_drive,
                     exp_rsp.wheel3_drive, rsp_payload.wheel0_drive,
                     rsp_payload.wheel1_drive, rsp_payload.wheel2_drive,
                     rsp_payload.wheel3_drive);
               end
            end
         end
      end
   end

   // Extremes of each field, every quadrant and the heading wrap.
   task automatic test_directed();
      logic [8:0] headings[12];
      headings = '{9'd0, 9'd45, 9'd90, 9'd135, 9'd180, 9'd225, 9'd270, 9'd315,
                   9'd359, 9'd360, 9'd511, 9'd1};
      foreach (headings[i]) begin
         send_request(headings[i], 16'h7FFF, 16'h0000);
      end
      send_request(9'd0, 16'h8000, 16'h8000);
      send_request(9'd90, 16'h7FFF, 16'h7FFF);
      send_request(9'd45, 16'h8000, 16'h0000);
      send_request(9'd0, 16'h0000, 16'h8000);
      send_request(9'd0, 16'h0000, 16'h7FFF);
      send_request(9'd180, 16'h0000, 16'h0000);
      send_request(9'd30, 16'h4000, 16'hC000);
      send_request(9'd300, 16'hFFFF, 16'h0001);
      send_request(9'd400, 16'h5555, 16'hAAAA);
      wait_drained();
   endtask

   // Random requests: mostly legal headings, some past 359.
   task automatic test_random(input int count);
      logic [8:0] hd;
      for (int i = 0; i < count; i++) begin
         hd = ($urandom_range(99) < 90) ? 9'($urandom_range(359)) : 9'($urandom_range(511));
         send_request(hd, 16'($urandom), ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
      end
   endtask

   // Long receiver hold-off while requests keep coming back to back, enough
   // of them to fill the pipeline and the queue, then a full drain.
   task automatic test_backpressure();
      send_gaps = 1'b0;
      hold_cycles <= 120;
      for (int i = 0; i < 80; i++) begin
         send_request(9'($urandom_range(359)), 16'($urandom), 16'($urandom));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      hold_cycles = 0;
      send_gaps = 1'b0;
      mismatch_count = 0;
      sent_count = 0;
      checked_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_gaps = 1'b1;
      test_random(760);
      wait_drained();
      test_backpressure();
      send_gaps = 1'b1;
      test_random(760);
      wait_drained();
      send_gaps = 1'b0;
      test_random(60);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Covered %0d drive requests, %0d responses checked, with stalls.",
               sent_count, checked_count);
      if (mismatch_count == 0) begin
         $display("PASS mecanum_drive_mixer");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL mecanum_drive_mixer");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #3000000;
      $display("Timeout");
      $display("FAIL mecanum_drive_mixer");
      $finish;
   end

endmodule

`default_nettype wire
